### hw/rtl/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/dcrc_pkg.sv
// Types and constants shared by the radix converter modules
`default_nettype none

package dcrc_pkg;

    localparam int CODED_W   = 31;
    localparam int BASE_W    = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int STAT_W    = 2;

    localparam int VALUE_W  = 31;
    localparam int WEIGHT_W = 30;

    localparam logic [BASE_W-1:0] BASE_MIN  = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX  = 4'd10;
    localparam logic [BASE_W-1:0] DEC_RADIX = 4'd10;

    // Shared divider: 32-bit dividend, eight quotient bits per cycle
    localparam int DIV_W     = 32;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    to_out;
        logic    div_start;
        logic    div_ten;
        logic    in_acc;
        logic    out_acc;
        logic    out_load;
        status_t code;
    } dcrc_cmd_t;

    typedef struct packed {
        logic bad_base;
        logic num_zero;
        logic in_last;
        logic out_last;
        logic div_done;
        logic out_free;
    } dcrc_stat_t;

endpackage

`default_nettype wire

### hw/rtl/dcrc_div.sv
// Iterative divider by a small divisor, eight quotient bits per cycle
`default_nettype none

module dcrc_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [dcrc_pkg::DIV_W-1:0]   dividend,
    input  wire logic [dcrc_pkg::BASE_W-1:0]  divisor,
    output logic                              done,
    output logic [dcrc_pkg::DIV_W-1:0]        quotient,
    output logic [dcrc_pkg::BASE_W-1:0]       remainder
);
    import dcrc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [BASE_W-1:0]    r_reg, r_next;
    logic [BASE_W-1:0]    d_reg, d_next;
    logic [DIV_W-1:0]     q_step;
    logic [BASE_W-1:0]    r_step;

    // Restoring division over DIV_BITS bits; remainder stays below the divisor
    always_comb begin
        logic [BASE_W:0] t;
        q_step = q_reg;
        r_step = r_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t      = {r_step, q_step[DIV_W-1]};
            q_step = {q_step[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d_reg}) begin
                t         = t - {1'b0, d_reg};
                q_step[0] = 1'b1;
            end
            r_step = t[BASE_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next   = q_step;
            r_next   = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

### hw/rtl/dcrc_datapath.sv
// Datapath: digit weighing, target-base packing and output register
`default_nettype none

module dcrc_datapath #(
    parameter int MAX_IN_DIGITS  = 10,
    parameter int MAX_OUT_DIGITS = 19
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dcrc_pkg::dcrc_cmd_t              cmd,
    output dcrc_pkg::dcrc_stat_t                  stat,
    input  wire logic [dcrc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dcrc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [dcrc_pkg::STAT_W-1:0]           m_tuser
);
    import dcrc_pkg::*;

    localparam int IN_CNT_W  = $clog2(MAX_IN_DIGITS + 1);
    localparam int OUT_CNT_W = $clog2(MAX_OUT_DIGITS + 1);

    logic [CODED_W-1:0] in_coded;
    logic [BASE_W-1:0]  in_sb, in_tb;

    logic [VALUE_W-1:0]   num_reg, num_next;
    logic [BASE_W-1:0]    sb_reg, sb_next;
    logic [BASE_W-1:0]    tb_reg, tb_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [M_TDATA_W-1:0] packed_reg, packed_next;
    logic [M_TDATA_W-1:0] scale_reg, scale_next;
    logic [IN_CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [BASE_W-1:0]        div_rem;
    logic [BASE_W-1:0]        div_divisor;
    logic [WEIGHT_W+BASE_W-1:0] digit_term;
    logic [WEIGHT_W+BASE_W-1:0] weight_prod;
    logic [M_TDATA_W-1:0]     out_term;

    assign in_coded = s_tdata[CODED_W-1:0];
    assign in_sb    = s_tdata[CODED_W +: BASE_W];
    assign in_tb    = s_tdata[CODED_W+BASE_W +: BASE_W];

    assign div_divisor = cmd.div_ten ? DEC_RADIX : tb_reg;

    dcrc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  ({{(DIV_W-VALUE_W){1'b0}}, num_reg}),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign digit_term  = div_rem * weight_reg;
    assign weight_prod = weight_reg * sb_reg;
    assign out_term    = {{(M_TDATA_W-BASE_W){1'b0}}, div_rem} * scale_reg;

    always_comb begin
        num_next     = num_reg;
        sb_next      = sb_reg;
        tb_next      = tb_reg;
        value_next   = value_reg;
        weight_next  = weight_reg;
        packed_next  = packed_reg;
        scale_next   = scale_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        if (cmd.load) begin
            num_next     = in_coded;
            sb_next      = in_sb;
            tb_next      = in_tb;
            value_next   = '0;
            weight_next  = WEIGHT_W'(1);
            packed_next  = '0;
            scale_next   = M_TDATA_W'(1);
            in_cnt_next  = '0;
            out_cnt_next = '0;
        end
        if (cmd.to_out) begin
            num_next = value_reg;
        end
        if (cmd.in_acc) begin
            num_next    = div_quo[VALUE_W-1:0];
            value_next  = value_reg + digit_term[VALUE_W-1:0];
            weight_next = weight_prod[WEIGHT_W-1:0];
            in_cnt_next = in_cnt_reg + 1'b1;
        end
        if (cmd.out_acc) begin
            num_next     = div_quo[VALUE_W-1:0];
            packed_next  = packed_reg + out_term;
            scale_next   = (scale_reg << 3) + (scale_reg << 1);
            out_cnt_next = out_cnt_reg + 1'b1;
        end
    end

    // Output register: hold until taken, accept a new result when free
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = (cmd.code == ST_OK) ? packed_reg : '0;
            m_tuser_next  = cmd.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg     <= num_next;
        sb_reg      <= sb_next;
        tb_reg      <= tb_next;
        value_reg   <= value_next;
        weight_reg  <= weight_next;
        packed_reg  <= packed_next;
        scale_reg   <= scale_next;
        in_cnt_reg  <= in_cnt_next;
        out_cnt_reg <= out_cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign stat.bad_base = (in_sb < BASE_MIN) || (in_sb > BASE_MAX) ||
                           (in_tb < BASE_MIN) || (in_tb > BASE_MAX);
    assign stat.num_zero = (num_reg == '0);
    assign stat.in_last  = (in_cnt_reg == IN_CNT_W'(MAX_IN_DIGITS));
    assign stat.out_last = (out_cnt_reg == OUT_CNT_W'(MAX_OUT_DIGITS));
    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### hw/rtl/dcrc_ctrl.sv
// Controller state machine sequencing the digit loops
`default_nettype none

module dcrc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire dcrc_pkg::dcrc_stat_t  stat,
    output dcrc_pkg::dcrc_cmd_t        cmd
);
    import dcrc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_IN_CHECK  = 8'b0000_0010,
        S_IN_DIV    = 8'b0000_0100,
        S_IN_ACC    = 8'b0000_1000,
        S_OUT_CHECK = 8'b0001_0000,
        S_OUT_DIV   = 8'b0010_0000,
        S_OUT_ACC   = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.code      = code_reg;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.bad_base) begin
                        code_next  = ST_BAD_BASE;
                        state_next = S_FINISH;
                    end else begin
                        code_next  = ST_OK;
                        state_next = S_IN_CHECK;
                    end
                end
            end
            S_IN_CHECK: begin
                // Stop weighing once the coded number runs out of digits or the input digit limit is reached
                if (stat.num_zero || stat.in_last) begin
                    cmd.to_out = 1'b1;
                    state_next = S_OUT_CHECK;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_ten   = 1'b1;
                    state_next    = S_IN_DIV;
                end
            end
            S_IN_DIV: begin
                if (stat.div_done) begin
                    state_next = S_IN_ACC;
                end
            end
            S_IN_ACC: begin
                cmd.in_acc = 1'b1;
                state_next = S_IN_CHECK;
            end
            S_OUT_CHECK: begin
                if (stat.num_zero) begin
                    state_next = S_FINISH;
                end else if (stat.out_last) begin
                    code_next  = ST_OVERFLOW;
                    state_next = S_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_OUT_DIV;
                end
            end
            S_OUT_DIV: begin
                if (stat.div_done) begin
                    state_next = S_OUT_ACC;
                end
            end
            S_OUT_ACC: begin
                cmd.out_acc = 1'b1;
                state_next  = S_OUT_CHECK;
            end
            S_FINISH: begin
                // Hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/decimal_coded_radix_converter.sv
// Top level: decimal-coded radix converter
// Input transfer to result valid: a bad base goes straight to the result; otherwise the input
// digits are weighed and then the output digits are produced, one digit at a time.
// Each digit passes a check, four 8-bit divider steps, the divider's done and an accumulate step.
// Throughput: one item in work at a time; the next transfer can follow in the cycle after the
// result loads. A new item is taken while the previous result waits in the output register.
// Reset (aresetn low, synchronous) empties the output and returns to idle.
`default_nettype none

module decimal_coded_radix_converter #(
    parameter int MAX_IN_DIGITS  = 10,
    parameter int MAX_OUT_DIGITS = 19
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // coded_number[30:0], source_base[34:31], target_base[38:35], zero pad[39]
    input  wire logic [dcrc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // converted_number[63:0]
    output logic [dcrc_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [dcrc_pkg::STAT_W-1:0]          m_tuser
);
    import dcrc_pkg::*;

    dcrc_cmd_t  cmd;
    dcrc_stat_t stat;

    dcrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dcrc_datapath #(
        .MAX_IN_DIGITS  (MAX_IN_DIGITS),
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/dcrc_checker.sv
// Port checker for the radix converter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module dcrc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dcrc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [dcrc_pkg::STAT_W-1:0]     m_tuser
);
    import dcrc_pkg::*;

    // Any error status carries a zero number
    `ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)

    // One item in work at a time: input closes right after a transfer
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the output
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind decimal_coded_radix_converter dcrc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/decimal_coded_radix_converter_checker.sv
`timescale 1ns / 1ps
// Checker for the radix converter: predicts each conversion and compares the results

module decimal_coded_radix_converter_checker #(
    parameter int MAX_IN_DIGITS  = 10,
    parameter int MAX_OUT_DIGITS = 19
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    // coded_number[30:0], source_base[34:31], target_base[38:35], zero pad[39]
    input  wire logic [dcrc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    // converted_number[63:0]
    input  wire logic [dcrc_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    input  wire logic [dcrc_pkg::STAT_W-1:0]      m_tuser,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    ok_count,
    output int                                    bad_base_count,
    output int                                    overflow_count
);
    import dcrc_pkg::*;

    typedef struct {
        logic [M_TDATA_W-1:0] number;
        status_t              status;
    } conversion_t;

    conversion_t awaited_conversions[$];

    function automatic conversion_t convert_radix(input logic [CODED_W-1:0] coded,
                                                  input logic [BASE_W-1:0]  src_base,
                                                  input logic [BASE_W-1:0]  dst_base);
        conversion_t r;
        logic [63:0] rest;
        logic [63:0] value;
        logic [63:0] weight;
        logic [63:0] digits_acc;
        logic [63:0] scale;
        int          n;
        int          i;
        r.number = '0;
        r.status = ST_OK;
        if (src_base < BASE_MIN || src_base > BASE_MAX ||
            dst_base < BASE_MIN || dst_base > BASE_MAX) begin
            r.status = ST_BAD_BASE;
            return r;
        end
        rest   = 64'(coded);
        value  = '0;
        weight = 64'd1;
        // digits at or above the source base are weighted as they stand
        for (i = 0; i < MAX_IN_DIGITS && rest != 0; i++) begin
            value  = value + (rest % 64'd10) * weight;
            rest   = rest / 64'd10;
            weight = weight * 64'(src_base);
        end
        digits_acc = '0;
        scale      = 64'd1;
        n          = 0;
        while (value != 0) begin
            if (n >= MAX_OUT_DIGITS) begin
                r.status = ST_OVERFLOW;
                return r;
            end
            digits_acc = digits_acc + (value % 64'(dst_base)) * scale;
            value      = value / 64'(dst_base);
            n++;
            if (n < MAX_OUT_DIGITS)
                scale = scale * 64'd10;
        end
        r.number = digits_acc;
        return r;
    endfunction

    initial begin
        fail_count     = 0;
        pending        = 0;
        ok_count       = 0;
        bad_base_count = 0;
        overflow_count = 0;
    end

    always @(posedge aclk) begin : watch
        conversion_t want;
        int          errs;
        errs = 0;
        if (aresetn) begin
            // pop before push: no result can belong to an item taken this same edge
            if (m_tvalid && m_tready) begin
                if (awaited_conversions.size() == 0) begin
                    $error("result with no conversion pending: number %0d status %0d",
                           m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = awaited_conversions.pop_front();
                    if (m_tdata !== want.number) begin
                        $error("converted_number mismatch: expected %0d, actual %0d",
                               want.number, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser);
                        errs++;
                    end
                    case (want.status)
                        ST_OK:       ok_count       <= ok_count + 1;
                        ST_BAD_BASE: bad_base_count <= bad_base_count + 1;
                        default:     overflow_count <= overflow_count + 1;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                awaited_conversions.push_back(convert_radix(s_tdata[30:0], s_tdata[34:31],
                                                            s_tdata[38:35]));
            pending    <= awaited_conversions.size();
            fail_count <= fail_count + errs;
        end
    end

endmodule

### verif/decimal_coded_radix_converter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the radix converter: clock, reset, stimulus, watchdog and verdict

module decimal_coded_radix_converter_tb;
    import dcrc_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    int fail_count;
    int pending;
    int ok_count;
    int bad_base_count;
    int overflow_count;
    int stall_cycles;
    bit steady;

    decimal_coded_radix_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    decimal_coded_radix_converter_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending        (pending),
        .ok_count       (ok_count),
        .bad_base_count (bad_base_count),
        .overflow_count (overflow_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
    end

    // result side: stall at random about 14 percent of the time, never during the steady stretch
    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 14);

    // end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_conversion(input logic [CODED_W-1:0] coded,
                                   input logic [BASE_W-1:0]  src_base,
                                   input logic [BASE_W-1:0]  dst_base);
        int gap;
        gap = (!steady && $urandom_range(99) < 14) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, dst_base, src_base, coded};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // digits drawn below the source base, so the number reads as a proper source-base value
    function automatic logic [CODED_W-1:0] digits_in_base(input logic [BASE_W-1:0] src_base);
        logic [63:0] acc;
        int          n;
        int          k;
        acc = '0;
        n   = $urandom_range(1, 10);
        for (k = 0; k < n; k++)
            acc = acc * 64'd10 + 64'($urandom_range(src_base - 1));
        // drop the leading digit if the number no longer fits the field
        if (acc > 64'd2147483647)
            acc = acc % 64'd1000000000;
        return acc[CODED_W-1:0];
    endfunction

    initial begin : stimulus
        logic [BASE_W-1:0]  sb;
        logic [BASE_W-1:0]  tb;
        logic [CODED_W-1:0] coded;
        int                 k;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero input, bad bases on each side, field extremes
        send_conversion(31'd0, 4'd10, 4'd2);
        send_conversion(31'd0, 4'd0, 4'd0);
        send_conversion(31'd123, 4'd1, 4'd10);
        send_conversion(31'd123, 4'd11, 4'd10);
        send_conversion(31'd123, 4'd10, 4'd1);
        send_conversion(31'd123, 4'd10, 4'd11);
        send_conversion(31'd123, 4'd15, 4'd15);
        send_conversion(31'd2147483647, 4'd10, 4'd10);
        send_conversion(31'd2147483647, 4'd10, 4'd2);
        // nineteen binary digits fit, twenty overflow
        send_conversion(31'd524287, 4'd10, 4'd2);
        send_conversion(31'd524288, 4'd10, 4'd2);
        send_conversion(31'd1111111111, 4'd2, 4'd10);
        // digits not below the source base, then assorted base pairs
        send_conversion(31'd999, 4'd2, 4'd10);
        send_conversion(31'd2147483647, 4'd9, 4'd3);
        send_conversion(31'd1, 4'd2, 4'd2);
        send_conversion(31'd10, 4'd10, 4'd9);
        send_conversion(31'd1234567890, 4'd9, 4'd7);
        send_conversion(31'd1010101010, 4'd2, 4'd3);
        send_conversion(31'd2000000000, 4'd3, 4'd2);
        send_conversion(31'd1777777777, 4'd8, 4'd4);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k >= 400 && k < 600);
            if ($urandom_range(99) < 85) begin
                sb = 4'($urandom_range(BASE_MAX, BASE_MIN));
                tb = 4'($urandom_range(BASE_MAX, BASE_MIN));
            end else begin
                sb = 4'($urandom_range(15));
                tb = 4'($urandom_range(15));
            end
            if (sb >= BASE_MIN && sb <= BASE_MAX && $urandom_range(1))
                coded = digits_in_base(sb);
            else
                coded = 31'($urandom) >> $urandom_range(30);
            send_conversion(coded, sb, tb);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d numbers: %0d ok, %0d rejected for base, %0d too long.",
                 ok_count + bad_base_count + overflow_count, ok_count, bad_base_count,
                 overflow_count);
        $display("Both channels stalled at random, with one stretch of back-to-back transfers.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
